// ===== src/vru_pkg.sv =====
// Shared constants for the vector refraction unit.
package vru_pkg;

  // Default input word size and binary point position.
  localparam int VEC_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 14;

  // Width of each refracted component on the result channel.
  localparam int OUT_W = 24;

  // Intermediate values are held in 31 bits signed and clamped to +-(2^30-1).
  localparam int MID_W = 31;
  // The magnitude under the root is unsigned and clamped to at most 2^30-1.
  localparam int D_W = 30;

  localparam longint MID_LIMIT = 64'sd1073741823;
  localparam longint OUT_MAX   = 64'sd8388607;
  localparam longint OUT_MIN   = -64'sd8388608;

endpackage

// ===== src/vru_sqrt.sv =====
// Pipelined floored integer square root, one root bit per stage, with sideband.
module vru_sqrt #(
  parameter int ROOT_W = 22,
  parameter int SIDE_W = 141
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 1;

  logic              valid_r  [ROOT_W];
  logic [RAD_W-1:0]  rad_r    [ROOT_W];
  logic [REM_W-1:0]  rem_r    [ROOT_W];
  logic [ROOT_W-1:0] root_r   [ROOT_W];
  logic [SIDE_W-1:0] side_r   [ROOT_W];

  logic              valid_nxt [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt   [ROOT_W];
  logic [REM_W-1:0]  rem_nxt   [ROOT_W];
  logic [ROOT_W-1:0] root_nxt  [ROOT_W];
  logic [SIDE_W-1:0] side_nxt  [ROOT_W];

  // Each stage brings down the next two radicand bits and tries the next root bit.
  always_comb begin
    logic              v_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  rem_cat;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              take;
    for (int g = 0; g < ROOT_W; g++) begin
      if (g == 0) begin
        v_in    = in_valid;
        rad_in  = in_rad;
        rem_in  = '0;
        root_in = '0;
        side_in = in_side;
      end else begin
        v_in    = valid_r[g-1];
        rad_in  = rad_r[g-1];
        rem_in  = rem_r[g-1];
        root_in = root_r[g-1];
        side_in = side_r[g-1];
      end
      rem_cat = {rem_in, rad_in[RAD_W-1 -: 2]};
      trial   = {1'b0, root_in, 2'b01};
      take    = (rem_cat >= trial);
      diff    = rem_cat - trial;
      valid_nxt[g] = v_in;
      rad_nxt[g]   = rad_in << 2;
      rem_nxt[g]   = take ? diff[REM_W-1:0] : rem_cat[REM_W-1:0];
      root_nxt[g]  = {root_in[ROOT_W-2:0], take};
      side_nxt[g]  = side_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < ROOT_W; g++) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (en) begin
        valid_r[g] <= valid_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < ROOT_W; g++) begin
        rad_r[g]  <= rad_nxt[g];
        rem_r[g]  <= rem_nxt[g];
        root_r[g] <= root_nxt[g];
        side_r[g] <= side_nxt[g];
      end
    end
  end

  assign out_valid = valid_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

// ===== src/vector_refraction_unit.sv =====
// Top level of the vector refraction unit: Snell's law refraction in fixed point.
// Throughput is one word per cycle: the pipeline takes a new word in every cycle in
// which the output register is empty or being emptied. The square root yields one root
// bit per stage, ROOT_W = (30 + FRAC_BITS + 1) / 2 root bits in all, which sets the
// depth. Reset clears every stage valid bit at once, so the block comes out of reset
// empty and ready.
module vector_refraction_unit #(
  parameter int VEC_WIDTH = vru_pkg::VEC_WIDTH_DEF,
  parameter int FRAC_BITS = vru_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [VEC_WIDTH-1:0]        in_incident_x,
  input  logic signed [VEC_WIDTH-1:0]        in_incident_y,
  input  logic signed [VEC_WIDTH-1:0]        in_incident_z,
  input  logic signed [VEC_WIDTH-1:0]        in_normal_x,
  input  logic signed [VEC_WIDTH-1:0]        in_normal_y,
  input  logic signed [VEC_WIDTH-1:0]        in_normal_z,
  input  logic        [VEC_WIDTH-1:0]        in_index_ratio,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vru_pkg::OUT_W-1:0]   out_refracted_x,
  output logic signed [vru_pkg::OUT_W-1:0]   out_refracted_y,
  output logic signed [vru_pkg::OUT_W-1:0]   out_refracted_z
);

  import vru_pkg::*;

  localparam int W = VEC_WIDTH;
  localparam int F = FRAC_BITS;

  // Stage widths. Each product is formed at full width and floored by an
  // arithmetic right shift, which rounds toward minus infinity.
  localparam int P1_W   = 2 * W;
  localparam int N1_W   = P1_W + 1;
  localparam int S1_W   = (N1_W + 2 > MID_W + 1) ? N1_W + 2 : MID_W + 1;
  localparam int P3_W   = MID_W + W;
  localparam int S4_W   = P3_W + 1;
  localparam int P5_W   = MID_W + W + 1;
  localparam int P7_W   = 2 * MID_W;
  localparam int S8_W   = P7_W + 3;
  localparam int ROOT_W = (D_W + F + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int P9_W   = ROOT_W + 1 + W;
  localparam int N9_W   = P9_W + 1;
  localparam int S10_W  = ((N9_W > MID_W) ? N9_W : MID_W) + 1;
  localparam int SIDE_W = 3 * MID_W + 3 * W;

  localparam logic signed [MID_W-1:0] MID_HI = MID_W'(MID_LIMIT);
  localparam logic signed [MID_W-1:0] MID_LO = -MID_HI;
  localparam logic signed [S1_W-1:0]  C1_HI  = S1_W'(MID_LIMIT);
  localparam logic signed [S1_W-1:0]  C1_LO  = -C1_HI;
  localparam logic signed [S4_W-1:0]  C4_HI  = S4_W'(MID_LIMIT);
  localparam logic signed [S4_W-1:0]  C4_LO  = -C4_HI;
  localparam logic signed [P5_W-1:0]  C6_HI  = P5_W'(MID_LIMIT);
  localparam logic signed [P5_W-1:0]  C6_LO  = -C6_HI;
  localparam logic signed [S8_W-1:0]  C8_HI  = S8_W'(MID_LIMIT);
  localparam logic signed [S8_W-1:0]  ONE8   = S8_W'(64'sd1 << FRAC_BITS);
  localparam logic        [D_W-1:0]   D_MAX  = D_W'(MID_LIMIT);
  localparam logic signed [S10_W-1:0] SAT_HI = S10_W'(OUT_MAX);
  localparam logic signed [S10_W-1:0] SAT_LO = S10_W'(OUT_MIN);

  // The whole pipeline moves together. It advances whenever the output register
  // is empty or its word is taken in this cycle, so a stall neither drops nor
  // repeats a word. Bubbles keep their places; an empty output register is
  // refilled in the next cycle whether or not the receiver is ready.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic signed [W-1:0] in_u [3];
  logic signed [W-1:0] in_n [3];
  assign in_u[0] = in_incident_x;
  assign in_u[1] = in_incident_y;
  assign in_u[2] = in_incident_z;
  assign in_n[0] = in_normal_x;
  assign in_n[1] = in_normal_y;
  assign in_n[2] = in_normal_z;

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  logic sq_valid;

  // Stage 1: products u_i * n_i for the cosine term.
  logic signed [P1_W-1:0] un1_r [3];
  logic signed [P1_W-1:0] un1_nxt [3];
  logic signed [W-1:0]    u1_r [3];
  logic signed [W-1:0]    n1_r [3];
  logic        [W-1:0]    r1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      un1_nxt[i] = in_u[i] * in_n[i];
    end
  end

  // Stage 2: c = sum of floor(-(u_i*n_i)), clamped.
  logic signed [MID_W-1:0] c2_r;
  logic signed [MID_W-1:0] c2_nxt;
  logic signed [W-1:0]     u2_r [3];
  logic signed [W-1:0]     n2_r [3];
  logic        [W-1:0]     r2_r;

  always_comb begin
    logic signed [N1_W-1:0] neg;
    logic signed [S1_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg = -un1_r[i];
      sum = sum + (neg >>> F);
    end
    if (sum > C1_HI) begin
      c2_nxt = MID_HI;
    end else if (sum < C1_LO) begin
      c2_nxt = MID_LO;
    end else begin
      c2_nxt = sum[MID_W-1:0];
    end
  end

  // Stage 3: products c * n_i.
  logic signed [P3_W-1:0] cn3_r [3];
  logic signed [P3_W-1:0] cn3_nxt [3];
  logic signed [W-1:0]    u3_r [3];
  logic signed [W-1:0]    n3_r [3];
  logic        [W-1:0]    r3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cn3_nxt[i] = c2_r * n2_r[i];
    end
  end

  // Stage 4: t_i = u_i + floor(c*n_i), clamped.
  logic signed [MID_W-1:0] t4_r [3];
  logic signed [MID_W-1:0] t4_nxt [3];
  logic signed [W-1:0]     n4_r [3];
  logic        [W-1:0]     r4_r;

  always_comb begin
    logic signed [S4_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = u3_r[i] + (cn3_r[i] >>> F);
      if (sum > C4_HI) begin
        t4_nxt[i] = MID_HI;
      end else if (sum < C4_LO) begin
        t4_nxt[i] = MID_LO;
      end else begin
        t4_nxt[i] = sum[MID_W-1:0];
      end
    end
  end

  // Stage 5: products t_i * ratio, with the ratio taken as unsigned.
  logic signed [P5_W-1:0] tr5_r [3];
  logic signed [P5_W-1:0] tr5_nxt [3];
  logic signed [W-1:0]    n5_r [3];
  logic signed [W:0]      ratio_s;

  assign ratio_s = {1'b0, r4_r};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tr5_nxt[i] = t4_r[i] * ratio_s;
    end
  end

  // Stage 6: perpendicular part p_i = floor(t_i * ratio), clamped.
  logic signed [MID_W-1:0] p6_r [3];
  logic signed [MID_W-1:0] p6_nxt [3];
  logic signed [W-1:0]     n6_r [3];

  always_comb begin
    logic signed [P5_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh = tr5_r[i] >>> F;
      if (sh > C6_HI) begin
        p6_nxt[i] = MID_HI;
      end else if (sh < C6_LO) begin
        p6_nxt[i] = MID_LO;
      end else begin
        p6_nxt[i] = sh[MID_W-1:0];
      end
    end
  end

  // Stage 7: squares p_i * p_i.
  logic signed [P7_W-1:0]  pp7_r [3];
  logic signed [P7_W-1:0]  pp7_nxt [3];
  logic signed [MID_W-1:0] p7_r [3];
  logic signed [W-1:0]     n7_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp7_nxt[i] = p6_r[i] * p6_r[i];
    end
  end

  // Stage 8: d = |1 - |p|^2|, clamped. Past total internal reflection the
  // magnitude is used as it stands.
  logic        [D_W-1:0]   d8_r;
  logic        [D_W-1:0]   d8_nxt;
  logic signed [MID_W-1:0] p8_r [3];
  logic signed [W-1:0]     n8_r [3];

  always_comb begin
    logic signed [S8_W-1:0] len2;
    logic signed [S8_W-1:0] diff;
    len2 = '0;
    for (int i = 0; i < 3; i++) begin
      len2 = len2 + (pp7_r[i] >>> F);
    end
    diff = ONE8 - len2;
    if (diff < 0) begin
      diff = -diff;
    end
    if (diff > C8_HI) begin
      d8_nxt = D_MAX;
    end else begin
      d8_nxt = diff[D_W-1:0];
    end
  end

  // Square root of d scaled by 2^F; p and n ride along as sideband.
  logic [RAD_W-1:0]  sq_rad;
  logic [SIDE_W-1:0] sq_side_in;
  logic [SIDE_W-1:0] sq_side_out;
  logic [ROOT_W-1:0] sq_root;

  assign sq_rad = RAD_W'({d8_r, {F{1'b0}}});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_side_in[i*W +: W]                 = n8_r[i];
      sq_side_in[3*W + i*MID_W +: MID_W]   = p8_r[i];
    end
  end

  vru_sqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v8_r),
    .in_rad    (sq_rad),
    .in_side   (sq_side_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side_out)
  );

  logic signed [W-1:0]     n_sq [3];
  logic signed [MID_W-1:0] p_sq [3];
  logic signed [ROOT_W:0]  root_s;

  assign root_s = {1'b0, sq_root};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_sq[i] = sq_side_out[i*W +: W];
      p_sq[i] = sq_side_out[3*W + i*MID_W +: MID_W];
    end
  end

  // Stage 9: products s * n_i for the parallel part.
  logic signed [P9_W-1:0]  sn9_r [3];
  logic signed [P9_W-1:0]  sn9_nxt [3];
  logic signed [MID_W-1:0] p9_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sn9_nxt[i] = root_s * n_sq[i];
    end
  end

  // Stage 10: out_i = p_i + floor(-(s*n_i)), saturated into the output register.
  logic signed [OUT_W-1:0] out10_r [3];
  logic signed [OUT_W-1:0] out10_nxt [3];

  always_comb begin
    logic signed [N9_W-1:0]  neg;
    logic signed [S10_W-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      neg = -sn9_r[i];
      sum = p9_r[i] + (neg >>> F);
      if (sum > SAT_HI) begin
        out10_nxt[i] = SAT_HI[OUT_W-1:0];
      end else if (sum < SAT_LO) begin
        out10_nxt[i] = SAT_LO[OUT_W-1:0];
      end else begin
        out10_nxt[i] = sum[OUT_W-1:0];
      end
    end
  end

  // Valid bits travel with the data and are the only state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v6_r  <= 1'b0;
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= sq_valid;
      v10_r <= v9_r;
    end
  end

  // Payload registers hold while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= in_index_ratio;
      r2_r <= r1_r;
      r3_r <= r2_r;
      r4_r <= r3_r;
      c2_r <= c2_nxt;
      d8_r <= d8_nxt;
      for (int i = 0; i < 3; i++) begin
        un1_r[i]   <= un1_nxt[i];
        u1_r[i]    <= in_u[i];
        n1_r[i]    <= in_n[i];
        u2_r[i]    <= u1_r[i];
        n2_r[i]    <= n1_r[i];
        cn3_r[i]   <= cn3_nxt[i];
        u3_r[i]    <= u2_r[i];
        n3_r[i]    <= n2_r[i];
        t4_r[i]    <= t4_nxt[i];
        n4_r[i]    <= n3_r[i];
        tr5_r[i]   <= tr5_nxt[i];
        n5_r[i]    <= n4_r[i];
        p6_r[i]    <= p6_nxt[i];
        n6_r[i]    <= n5_r[i];
        pp7_r[i]   <= pp7_nxt[i];
        p7_r[i]    <= p6_r[i];
        n7_r[i]    <= n6_r[i];
        p8_r[i]    <= p7_r[i];
        n8_r[i]    <= n7_r[i];
        sn9_r[i]   <= sn9_nxt[i];
        p9_r[i]    <= p_sq[i];
        out10_r[i] <= out10_nxt[i];
      end
    end
  end

  assign out_valid       = v10_r;
  assign out_refracted_x = out10_r[0];
  assign out_refracted_y = out10_r[1];
  assign out_refracted_z = out10_r[2];

endmodule

// ===== sim/vru_checker.sv =====
// Watches both channels of the refraction unit, predicts every result word and compares it.
module vru_checker (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic                                        in_ready,
  input  logic signed [vru_pkg::VEC_WIDTH_DEF-1:0]    in_incident_x,
  input  logic signed [vru_pkg::VEC_WIDTH_DEF-1:0]    in_incident_y,
  input  logic signed [vru_pkg::VEC_WIDTH_DEF-1:0]    in_incident_z,
  input  logic signed [vru_pkg::VEC_WIDTH_DEF-1:0]    in_normal_x,
  input  logic signed [vru_pkg::VEC_WIDTH_DEF-1:0]    in_normal_y,
  input  logic signed [vru_pkg::VEC_WIDTH_DEF-1:0]    in_normal_z,
  input  logic        [vru_pkg::VEC_WIDTH_DEF-1:0]    in_index_ratio,
  input  logic                                        out_valid,
  input  logic                                        out_ready,
  input  logic signed [vru_pkg::OUT_W-1:0]            out_refracted_x,
  input  logic signed [vru_pkg::OUT_W-1:0]            out_refracted_y,
  input  logic signed [vru_pkg::OUT_W-1:0]            out_refracted_z,
  output int                                          errors,
  output int                                          pending
);

  import vru_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  // Refracted direction as x, y, z from index 0 up.
  typedef logic [2:0][OUT_W-1:0] ray_dir_t;

  ray_dir_t expected_dirs[$];

  function automatic longint clamp_mid(input longint v);
    if (v > MID_LIMIT) return MID_LIMIT;
    if (v < -MID_LIMIT) return -MID_LIMIT;
    return v;
  endfunction

  // Floored integer square root, one result bit per pass.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned rem;
    longint unsigned acc;
    longint unsigned bitv;
    rem  = x;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= acc + bitv) begin
        rem -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  // Arithmetic right shifts of signed values floor toward minus infinity, which is the
  // rescaling rule used after every product.
  function automatic ray_dir_t refract_ray(
    input logic signed [VEC_WIDTH_DEF-1:0] ix, iy, iz, nx, ny, nz,
    input logic        [VEC_WIDTH_DEF-1:0] ratio
  );
    longint   u[3];
    longint   nv[3];
    longint   p[3];
    longint   r, cosv, len2, dmag, root, t, v;
    ray_dir_t res;
    u[0] = ix; u[1] = iy; u[2] = iz;
    nv[0] = nx; nv[1] = ny; nv[2] = nz;
    r = longint'(ratio);
    cosv = 0;
    for (int i = 0; i < 3; i++) cosv += (-(u[i] * nv[i])) >>> FRAC;
    cosv = clamp_mid(cosv);
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      t    = clamp_mid(u[i] + ((cosv * nv[i]) >>> FRAC));
      p[i] = clamp_mid((t * r) >>> FRAC);
      len2 += (p[i] * p[i]) >>> FRAC;
    end
    dmag = (longint'(1) << FRAC) - len2;
    if (dmag < 0) dmag = -dmag;
    if (dmag > MID_LIMIT) dmag = MID_LIMIT;
    root = longint'(floor_root(longint'(unsigned'(dmag)) << FRAC));
    for (int i = 0; i < 3; i++) begin
      v = p[i] + ((-(root * nv[i])) >>> FRAC);
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      res[i] = v[OUT_W-1:0];
    end
    return res;
  endfunction

  task automatic check_comp(input string name, input logic [OUT_W-1:0] exp_v,
                            input logic [OUT_W-1:0] act_v, inout int bad);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      bad++;
    end
  endtask

  always @(posedge clk) begin : watch
    int       bad;
    int       pushed;
    int       popped;
    ray_dir_t want;
    bad    = 0;
    pushed = 0;
    popped = 0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_dirs.push_back(refract_ray(in_incident_x, in_incident_y, in_incident_z,
                                            in_normal_x, in_normal_y, in_normal_z,
                                            in_index_ratio));
        pushed = 1;
      end
      if (out_valid && out_ready) begin
        if (expected_dirs.size() == 0) begin
          $error("result word with no expectation waiting: x=%0d y=%0d z=%0d",
                 out_refracted_x, out_refracted_y, out_refracted_z);
          bad++;
        end else begin
          want = expected_dirs.pop_front();
          popped = 1;
          check_comp("refracted_x", want[0], out_refracted_x, bad);
          check_comp("refracted_y", want[1], out_refracted_y, bad);
          check_comp("refracted_z", want[2], out_refracted_z, bad);
        end
      end
    end
    errors  <= errors + bad;
    pending <= pending + pushed - popped;
  end

endmodule

// ===== sim/tb_vector_refraction_unit.sv =====
// Testbench top for the vector refraction unit: stimulus, result-side stalls and verdict.
module tb_vector_refraction_unit;
  import vru_pkg::*;

  localparam int W = VEC_WIDTH_DEF;
  // Random words per idling phase; four phases give about 1950 words in all.
  localparam int WORDS_PER_PHASE = 488;
  // The final settle wait covers the pipeline depth with margin.
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_LIMIT = 200000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [W-1:0]    in_incident_x = '0;
  logic signed [W-1:0]    in_incident_y = '0;
  logic signed [W-1:0]    in_incident_z = '0;
  logic signed [W-1:0]    in_normal_x = '0;
  logic signed [W-1:0]    in_normal_y = '0;
  logic signed [W-1:0]    in_normal_z = '0;
  logic        [W-1:0]    in_index_ratio = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_refracted_x;
  logic signed [OUT_W-1:0] out_refracted_y;
  logic signed [OUT_W-1:0] out_refracted_z;

  int errors;
  int pending;

  // Percent chance, per cycle, that the sender holds off or the receiver stalls.
  // The stimulus process changes them between phases.
  int send_idle_pct = 0;
  int out_stall_pct = 0;

  vector_refraction_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_incident_x   (in_incident_x),
    .in_incident_y   (in_incident_y),
    .in_incident_z   (in_incident_z),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_index_ratio  (in_index_ratio),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_refracted_x (out_refracted_x),
    .out_refracted_y (out_refracted_y),
    .out_refracted_z (out_refracted_z)
  );

  // The checker sits beside the block, watching the same wires the block sees.
  vru_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_incident_x   (in_incident_x),
    .in_incident_y   (in_incident_y),
    .in_incident_z   (in_incident_z),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_index_ratio  (in_index_ratio),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_refracted_x (out_refracted_x),
    .out_refracted_y (out_refracted_y),
    .out_refracted_z (out_refracted_z),
    .errors          (errors),
    .pending         (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // A hard ceiling on the run. It lies well beyond what the slowest legal run needs,
  // with the receiver stalling in most cycles.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // The result side draws a fresh stall decision on every edge. A single nonblocking
  // assignment per edge keeps the ready level clean within a time step.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // Presents one word and holds it until the block takes it. Valid is only lowered
  // during a hold-off gap, so back-to-back words keep valid high across the edge.
  task automatic push_word(input logic signed [W-1:0] ix, iy, iz, nx, ny, nz,
                           input logic [W-1:0] ratio);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_incident_x  <= ix;
    in_incident_y  <= iy;
    in_incident_z  <= iz;
    in_normal_x    <= nx;
    in_normal_y    <= ny;
    in_normal_z    <= nz;
    in_index_ratio <= ratio;
    do @(posedge clk); while (!in_ready);
  endtask

  // A random direction scaled to unit length in Q1.14. Only the stimulus uses real
  // numbers; the checker works purely in integers.
  task automatic unit_dir(output logic signed [W-1:0] a, b, c);
    real x, y, z, m;
    do begin
      x = real'(int'($urandom_range(0, 2000000)) - 1000000) / 1.0e6;
      y = real'(int'($urandom_range(0, 2000000)) - 1000000) / 1.0e6;
      z = real'(int'($urandom_range(0, 2000000)) - 1000000) / 1.0e6;
      m = $sqrt(x * x + y * y + z * z);
    end while (m < 0.01);
    a = W'($rtoi(x / m * 16384.0));
    b = W'($rtoi(y / m * 16384.0));
    c = W'($rtoi(z / m * 16384.0));
  endtask

  // Values at and around the corners of the signed Q1.14 range.
  function automatic logic [W-1:0] corner_val();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'sh0001;
      5: return 16'sh4000;
      6: return 16'shc000;
      default: return W'($urandom);
    endcase
  endfunction

  // Most words are physical rays: unit incident and normal, ratio between 0.5 and 2.
  // The rest exercise the full bit patterns of every field and the corner values.
  task automatic random_word();
    logic signed [W-1:0] ix, iy, iz, nx, ny, nz;
    logic        [W-1:0] ratio;
    int                  kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      unit_dir(ix, iy, iz);
      unit_dir(nx, ny, nz);
      ratio = W'($urandom_range(8192, 32768));
    end else if (kind < 85) begin
      ix = W'($urandom); iy = W'($urandom); iz = W'($urandom);
      nx = W'($urandom); ny = W'($urandom); nz = W'($urandom);
      ratio = W'($urandom);
    end else begin
      ix = corner_val(); iy = corner_val(); iz = corner_val();
      nx = corner_val(); ny = corner_val(); nz = corner_val();
      ratio = ($urandom_range(0, 1) != 0) ? 16'hffff : corner_val();
    end
    push_word(ix, iy, iz, nx, ny, nz, ratio);
  endtask

  initial begin : stimulus
    int waited;

    // Reset is held from the start and released once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          out_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 81;
          out_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          out_stall_pct = 81;
        end
        default: begin
          send_idle_pct = 10;
          out_stall_pct = 10;
        end
      endcase

      if (phase == 0) begin
        // All fields zero.
        push_word(0, 0, 0, 0, 0, 0, 0);
        // Head-on ray at ratio one: goes straight through.
        push_word(0, 0, -16384, 0, 0, 16384, 16384);
        // Grazing ray along the surface.
        push_word(16384, 0, 0, 0, 0, 16384, 16384);
        // Steep ray into a thinner medium: total internal reflection.
        push_word(11585, 0, -11585, 0, 0, 16384, 24576);
        // Ratio zero leaves only the normal term.
        push_word(11585, 0, -11585, 0, 0, 16384, 0);
        // Largest ratio on an oblique ray.
        push_word(9459, 9459, -9459, 0, 0, 16384, 16'hffff);
        // Smallest nonzero ratio.
        push_word(9459, -9459, -9459, 0, 16384, 0, 1);
        // Every component at the positive limit, then at the negative limit.
        push_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'hffff);
        push_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'hffff);
        // Opposite limits on the two vectors.
        push_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'hffff);
        push_word(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'hffff);
        // Vectors far from unit length are used as they are.
        push_word(3000, -5000, 700, 100, 200, -300, 20000);
        // Smallest negative values everywhere, to probe flooring of tiny products.
        push_word(-1, -1, -1, -1, -1, -1, 1);
        // Zero normal: the parallel term vanishes.
        push_word(0, 16384, 0, 0, 0, 0, 16384);
        // Perpendicular part of exactly unit length leaves nothing under the root.
        push_word(16384, 0, 0, 0, 0, 16384, 16384);
        push_word(0, 8192, -14189, 0, 0, 16384, 32768);
      end

      repeat (WORDS_PER_PHASE) random_word();
    end
    in_valid <= 1'b0;

    // Let the result side run freely while the pipeline empties.
    out_stall_pct = 0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
